/* sv/ntsc_pkg.sv */
`default_nettype none
package ntsc_pkg;

   localparam int IDX_W  = 6;
   localparam int FVAL_W = 12;
   localparam int CHAR_W = 8;
   localparam int DIST_W = 18;
   localparam int CFG_W  = 7;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;
   localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic              is_query;
      logic [IDX_W-1:0]  tmpl;
      logic [IDX_W-1:0]  feat;
      logic              feat_ok;
      logic [FVAL_W-1:0] value;
      logic [CHAR_W-1:0] code;
      logic              last;
   } ntsc_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ntsc_q_stat_type;

   typedef struct packed {
      logic busy;
      logic emit;
   } ntsc_bk_stat_type;

endpackage
`default_nettype wire

/* sv/ntsc_req_if.sv */
`default_nettype none
interface ntsc_req_if;
   import ntsc_pkg::*;

   logic              valid;
   logic              ready;
   logic              req_type;
   logic [IDX_W-1:0]  template_index;
   logic [IDX_W-1:0]  feature_index;
   logic [FVAL_W-1:0] feature_value;
   logic [CHAR_W-1:0] char_code;
   logic              last;

   modport source (
      output valid, req_type, template_index, feature_index, feature_value, char_code, last,
      input  ready
   );
   modport sink (
      input  valid, req_type, template_index, feature_index, feature_value, char_code, last,
      output ready
   );
endinterface
`default_nettype wire

/* sv/ntsc_rsp_if.sv */
`default_nettype none
interface ntsc_rsp_if;
   import ntsc_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] best_char;
   logic [DIST_W-1:0] best_distance;

   modport source (output valid, best_char, best_distance, input ready);
   modport sink (input valid, best_char, best_distance, output ready);
endinterface
`default_nettype wire

/* sv/ntsc_csr_if.sv */
`default_nettype none
interface ntsc_csr_if;
   import ntsc_pkg::*;

   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] templates_in_use;

   modport source (output valid, templates_in_use, input ready);
   modport sink (input valid, templates_in_use, output ready);
endinterface
`default_nettype wire

/* sv/ntsc_front.sv */
`default_nettype none
module ntsc_front #(
   parameter int NUM_TEMPLATES = 64,
   parameter int FEATURES      = 64
) (
   ntsc_req_if.sink               req_ch,
   input  ntsc_pkg::ntsc_q_stat_type q_stat,
   output logic                   push,
   output ntsc_pkg::ntsc_cmd_type push_cmd
);
   import ntsc_pkg::*;

   logic accept;
   logic tmpl_ok;
   logic feat_ok;

   assign req_ch.ready = !q_stat.full;
   assign accept       = req_ch.valid && req_ch.ready;

   assign tmpl_ok = 9'(req_ch.template_index) < 9'(NUM_TEMPLATES);
   assign feat_ok = 9'(req_ch.feature_index) < 9'(FEATURES);

   always_comb begin
      push_cmd.is_query = (req_ch.req_type == REQ_QUERY);
      push_cmd.tmpl     = req_ch.template_index;
      push_cmd.feat     = req_ch.feature_index;
      push_cmd.feat_ok  = feat_ok;
      push_cmd.value    = req_ch.feature_value;
      push_cmd.code     = req_ch.char_code;
      push_cmd.last     = req_ch.last;
   end

   // loads outside the table are dropped here
   assign push = accept && ((req_ch.req_type == REQ_QUERY) || (tmpl_ok && feat_ok));

endmodule
`default_nettype wire

/* sv/ntsc_queue.sv */
`default_nettype none
module ntsc_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ntsc_pkg::ntsc_cmd_type    push_cmd,
   input  logic                      pop,
   output ntsc_pkg::ntsc_cmd_type    head_cmd,
   output ntsc_pkg::ntsc_q_stat_type q_stat
);
   import ntsc_pkg::*;

   ntsc_cmd_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd     = slot_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == 2'd2);
   assign q_stat.empty = (count_ff == 2'd0);

endmodule
`default_nettype wire

/* sv/ntsc_back.sv */
`default_nettype none
module ntsc_back #(
   parameter int NUM_TEMPLATES = 64,
   parameter int FEATURES      = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ntsc_pkg::ntsc_q_stat_type     q_stat,
   input  ntsc_pkg::ntsc_cmd_type        head_cmd,
   input  logic [$clog2(NUM_TEMPLATES+1)-1:0] active_n,
   output logic                          pop,
   output ntsc_pkg::ntsc_bk_stat_type    bk_stat,
   ntsc_rsp_if.source                    rsp_ch
);
   import ntsc_pkg::*;

   localparam int TW    = $clog2(NUM_TEMPLATES);
   localparam int FW    = (FEATURES > 1) ? $clog2(FEATURES) : 1;
   localparam int CNT_W = $clog2(NUM_TEMPLATES + 1);
   localparam int DEPTH = NUM_TEMPLATES * (2 ** FW);
   localparam logic [TW-1:0] LAST_T = TW'(NUM_TEMPLATES - 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SWEEP = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_CHAR  = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [FVAL_W-1:0] tmem [DEPTH];
   logic [DIST_W-1:0] dmem [NUM_TEMPLATES];
   logic [CHAR_W-1:0] cmem [NUM_TEMPLATES];

   logic [FW-1:0]     q_feat_ff;
   logic              q_feat_ok_ff;
   logic [FVAL_W-1:0] q_value_ff;
   logic              q_last_ff;

   logic [TW-1:0]     cnt_ff, cnt_in;
   logic              p_valid_ff;
   logic [TW-1:0]     p_idx_ff;
   logic [FVAL_W-1:0] tv_rd_ff;
   logic [DIST_W-1:0] dist_rd_ff;
   logic              fresh_ff, fresh_in;
   logic [TW-1:0]     best_idx_ff;
   logic [DIST_W-1:0] best_dist_ff;
   logic [CHAR_W-1:0] char_rd_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff;
   logic [DIST_W-1:0] rsp_dist_ff;

   logic              do_load;
   logic              start_query;
   logic              emit_load;
   logic [DIST_W-1:0] cur_dist;
   logic [FVAL_W-1:0] diff;
   logic [DIST_W:0]   sum_wide;
   logic [DIST_W-1:0] sum;
   logic              in_use;
   logic              take_best;

   assign pop         = (state_ff == ST_IDLE) && !q_stat.empty;
   assign do_load     = pop && !head_cmd.is_query;
   assign start_query = pop && head_cmd.is_query;
   assign emit_load   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ch.ready);

   // accumulate stage
   always_comb begin
      cur_dist = fresh_ff ? '0 : dist_rd_ff;
      if (!q_feat_ok_ff) begin
         diff = '0;
      end else if (q_value_ff > tv_rd_ff) begin
         diff = q_value_ff - tv_rd_ff;
      end else begin
         diff = tv_rd_ff - q_value_ff;
      end
      sum_wide  = {1'b0, cur_dist} + (DIST_W + 1)'(diff);
      sum       = sum_wide[DIST_W] ? DIST_MAX : sum_wide[DIST_W-1:0];
      in_use    = CNT_W'(p_idx_ff) < active_n;
      take_best = p_valid_ff && in_use && ((p_idx_ff == '0) || (sum < best_dist_ff));
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      fresh_in = fresh_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (start_query) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_T) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            fresh_in = q_last_ff;
            state_in = q_last_ff ? ST_CHAR : ST_IDLE;
         end
         ST_CHAR: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         p_valid_ff   <= 1'b0;
         fresh_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         p_valid_ff   <= (state_ff == ST_SWEEP);
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start_query) begin
         q_feat_ff    <= FW'(head_cmd.feat);
         q_feat_ok_ff <= head_cmd.feat_ok;
         q_value_ff   <= head_cmd.value;
         q_last_ff    <= head_cmd.last;
      end
      p_idx_ff <= cnt_ff;
      if (take_best) begin
         best_idx_ff  <= p_idx_ff;
         best_dist_ff <= sum;
      end
      if (emit_load) begin
         rsp_char_ff <= char_rd_ff;
         rsp_dist_ff <= best_dist_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (do_load) begin
         tmem[{TW'(head_cmd.tmpl), FW'(head_cmd.feat)}] <= head_cmd.value;
      end
      if (state_ff == ST_SWEEP) begin
         tv_rd_ff <= tmem[{cnt_ff, q_feat_ff}];
      end
   end

   always_ff @(posedge clock) begin
      if (p_valid_ff) begin
         dmem[p_idx_ff] <= sum;
      end
      if (state_ff == ST_SWEEP) begin
         dist_rd_ff <= dmem[cnt_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (do_load) begin
         cmem[TW'(head_cmd.tmpl)] <= head_cmd.code;
      end
      if (state_ff == ST_CHAR) begin
         char_rd_ff <= cmem[best_idx_ff];
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.best_char     = rsp_char_ff;
   assign rsp_ch.best_distance = rsp_dist_ff;

   assign bk_stat.busy = (state_ff != ST_IDLE);
   assign bk_stat.emit = emit_load;

endmodule
`default_nettype wire

/* sv/nearest_template_sad_classifier_core.sv */
// load: a load word is written into the template and char memories once it leaves the queue
// query: a query word sweeps every template, one template per cycle through the
// template and distance memories; the last word then fetches the char code and waits to emit
// throughput: a new query word is taken only once the back end is idle again; one load word per cycle while idle
// reset: synchronous; queue, sweep control and result valid flag clear, the
// distance sums read as zero until the first query word rewrites them
`default_nettype none
module nearest_template_sad_classifier_core #(
   parameter int NUM_TEMPLATES = 64,
   parameter int ZONE_ROWS     = 8,
   parameter int ZONE_COLS     = 8
) (
   input  logic       clock,
   input  logic       reset,
   ntsc_req_if.sink   req_ch,
   ntsc_rsp_if.source rsp_ch,
   ntsc_csr_if.sink   csr_ch
);
   import ntsc_pkg::*;

   localparam int FEATURES = ZONE_ROWS * ZONE_COLS;
   localparam int CNT_W    = $clog2(NUM_TEMPLATES + 1);

   logic [CFG_W-1:0] cfg_ff, cfg_in;
   logic [CNT_W-1:0] active_n;

   logic             push;
   logic             pop;
   ntsc_cmd_type     push_cmd;
   ntsc_cmd_type     head_cmd;
   ntsc_q_stat_type  q_stat;
   ntsc_bk_stat_type bk_stat;

   assign csr_ch.ready = 1'b1;
   assign cfg_in = (csr_ch.valid && csr_ch.ready) ? csr_ch.templates_in_use : cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      if (cfg_ff == '0) begin
         active_n = CNT_W'(1);
      end else if (9'(cfg_ff) > 9'(NUM_TEMPLATES)) begin
         active_n = CNT_W'(NUM_TEMPLATES);
      end else begin
         active_n = CNT_W'(cfg_ff);
      end
   end

   ntsc_front #(
      .NUM_TEMPLATES(NUM_TEMPLATES),
      .FEATURES     (FEATURES)
   ) u_front (
      .req_ch  (req_ch),
      .q_stat  (q_stat),
      .push    (push),
      .push_cmd(push_cmd)
   );

   ntsc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_cmd(push_cmd),
      .pop     (pop),
      .head_cmd(head_cmd),
      .q_stat  (q_stat)
   );

   ntsc_back #(
      .NUM_TEMPLATES(NUM_TEMPLATES),
      .FEATURES     (FEATURES)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_stat  (q_stat),
      .head_cmd(head_cmd),
      .active_n(active_n),
      .pop     (pop),
      .bk_stat (bk_stat),
      .rsp_ch  (rsp_ch)
   );

   a_active_range: assert property (@(posedge clock) disable iff (reset)
      (active_n != '0) && (active_n <= CNT_W'(NUM_TEMPLATES)))
      else $error("template count out of range");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("pop from empty queue");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(bk_stat.emit))
      else $error("result word without emit");

   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      bk_stat.emit |-> bk_stat.busy)
      else $error("emit while back end idle");

endmodule
`default_nettype wire
